// ----- rtl/pilp_pkg.sv -----
`timescale 1ns / 1ps

package pilp_pkg;

    // Width of the field that carries the parsed value on the result channel.
    localparam int unsigned VALUE_W    = 64;
    // Width of the internal accumulator; a value that does not fit is an overflow.
    localparam int unsigned VALUE_BITS = 64;

    localparam logic [1:0] STATUS_VALID    = 2'd0;
    localparam logic [1:0] STATUS_NOT_NUM  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [4:0] RADIX_NONE = 5'd0;
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         radix;
        logic [VALUE_W-1:0] value;
    } t_out_item;

endpackage

// ----- rtl/prefixed_integer_literal_parser.sv -----
`timescale 1ns / 1ps
// Result: the result of a token is registered and shown in the cycle after its last character is accepted.
// Throughput: one character per cycle; the per-character work is a shift-and-add step
// of the accumulator between the parse state registers and the result register. The
// input stalls only while a finished result waits in that register with i_out_ready low.
// Reset: i_rst_n is synchronous and active low; it returns the parser to the start of
// a token and empties the result register. No clearing pass is needed.
module prefixed_integer_literal_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pilp_pkg::t_in_item    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pilp_pkg::t_out_item   o_out_data
);
    import pilp_pkg::*;

    // The parser walks through these phases once per token.
    typedef enum logic [1:0] {
        PH_START  = 2'd0,   // skipping leading whitespace
        PH_ZERO   = 2'd1,   // a leading zero has been seen
        PH_DIGITS = 2'd2,   // inside the digit run
        PH_TRAIL  = 2'd3    // skipping trailing whitespace
    } t_phase_e;

    localparam logic [7:0] CH_DASH  = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // The product of the accumulator and a base of at most 16, plus a digit.
    localparam int unsigned PROD_W = VALUE_BITS + 5;

    // Parse state.
    t_phase_e              r_phase, n_phase;
    logic [4:0]            r_base, n_base;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ovf, n_ovf;
    logic                  r_rej, n_rej;
    logic                  r_dig, n_dig;

    // Result register.
    logic                  r_out_valid;
    t_out_item             r_out_data, n_out_data;

    logic                  w_accept;
    logic [7:0]            w_ch;
    logic                  w_is_space;
    logic                  w_is_hex;
    logic [3:0]            w_digit;
    logic [4:0]            w_acc_base;
    logic [PROD_W-1:0]     w_acc_ext;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W-1:0]     w_sum;
    logic                  w_sum_ovf;
    logic                  w_do_acc;
    logic                  w_ok;

    // A new character is taken whenever the result register is empty or is being
    // drained in the same cycle, so a result that leaves at once costs no bubble.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Fold upper case to lower case before any decoding.
    assign w_ch = (i_in_data.ch >= CH_UA && i_in_data.ch <= CH_UZ) ?
                  (i_in_data.ch + 8'd32) : i_in_data.ch;

    assign w_is_space = (w_ch == CH_SPACE) || (w_ch >= CH_TAB && w_ch <= CH_CR);

    always_comb begin
        w_is_hex = 1'b0;
        w_digit  = 4'd0;
        if (w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            w_is_hex = 1'b1;
            w_digit  = 4'(w_ch - CH_ZERO);
        end else if (w_ch >= CH_LA && w_ch <= CH_LF) begin
            w_is_hex = 1'b1;
            w_digit  = 4'(w_ch - CH_LA + 8'd10);
        end
    end

    // The base that a digit accepted in this cycle is weighed with: the first
    // decimal digit sets base ten, the first octal digit after a zero sets base
    // eight, and inside the run the stored base applies.
    always_comb begin
        case (r_phase)
            PH_START: w_acc_base = RADIX_DEC;
            PH_ZERO:  w_acc_base = RADIX_OCT;
            default:  w_acc_base = r_base;
        endcase
    end

    // Multiply by the base with shifts; ten is eight plus two.
    assign w_acc_ext = PROD_W'(r_acc);
    always_comb begin
        case (w_acc_base)
            RADIX_BIN: w_prod = w_acc_ext << 1;
            RADIX_OCT: w_prod = w_acc_ext << 3;
            RADIX_HEX: w_prod = w_acc_ext << 4;
            default:   w_prod = (w_acc_ext << 3) + (w_acc_ext << 1);
        endcase
    end

    // The new value overflows exactly when any bit above the accumulator width is set.
    assign w_sum     = w_prod + PROD_W'(w_digit);
    assign w_sum_ovf = |w_sum[PROD_W-1:VALUE_BITS];

    // Next parse state for one character, then the result when it ends the token.
    always_comb begin
        n_phase    = r_phase;
        n_base     = r_base;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_rej      = r_rej;
        n_dig      = r_dig;
        w_do_acc   = 1'b0;
        w_ok       = 1'b0;
        n_out_data = r_out_data;

        // Once a token is rejected, its remaining characters are ignored.
        if (!r_rej) begin
            if (w_ch == CH_DASH) begin
                n_rej = 1'b1;
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (w_is_space) begin
                            n_phase = PH_START;
                        end else if (w_ch == CH_ZERO) begin
                            n_phase = PH_ZERO;
                        end else if (w_ch >= CH_ONE && w_ch <= CH_NINE) begin
                            n_base   = RADIX_DEC;
                            n_phase  = PH_DIGITS;
                            n_dig    = 1'b1;
                            w_do_acc = 1'b1;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    PH_ZERO: begin
                        if (w_ch == CH_LB) begin
                            n_base  = RADIX_BIN;
                            n_phase = PH_DIGITS;
                        end else if (w_ch == CH_LX) begin
                            n_base  = RADIX_HEX;
                            n_phase = PH_DIGITS;
                        end else if (w_ch >= CH_ZERO && w_ch <= CH_SEVEN) begin
                            n_base   = RADIX_OCT;
                            n_phase  = PH_DIGITS;
                            n_dig    = 1'b1;
                            w_do_acc = 1'b1;
                        end else if (w_is_space) begin
                            // A lone zero followed by whitespace is decimal zero.
                            n_base  = RADIX_DEC;
                            n_phase = PH_TRAIL;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_is_hex && (5'(w_digit) < r_base)) begin
                            n_dig    = 1'b1;
                            w_do_acc = 1'b1;
                        end else if (w_is_space && r_dig) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    default: begin
                        if (!w_is_space) begin
                            n_rej = 1'b1;
                        end
                    end
                endcase
            end
        end

        // After an overflow the accumulator is frozen; only the flag matters.
        if (w_do_acc && !r_ovf) begin
            if (w_sum_ovf) begin
                n_ovf = 1'b1;
            end else begin
                n_acc = w_sum[VALUE_BITS-1:0];
            end
        end

        if (i_in_data.last) begin
            case (n_phase)
                PH_ZERO: begin
                    // A token that ends right after its leading zero is decimal zero.
                    n_base = RADIX_DEC;
                    w_ok   = 1'b1;
                end
                PH_DIGITS: w_ok = n_dig;
                PH_TRAIL:  w_ok = 1'b1;
                default:   w_ok = 1'b0;
            endcase
            if (n_rej) begin
                w_ok = 1'b0;
            end

            if (!w_ok) begin
                n_out_data.status = STATUS_NOT_NUM;
                n_out_data.radix  = RADIX_NONE;
                n_out_data.value  = '0;
            end else if (n_ovf) begin
                n_out_data.status = STATUS_OVERFLOW;
                n_out_data.radix  = n_base;
                n_out_data.value  = '0;
            end else begin
                n_out_data.status = STATUS_VALID;
                n_out_data.radix  = n_base;
                n_out_data.value  = VALUE_W'(n_acc);
            end

            // The next character starts a fresh token.
            n_phase = PH_START;
            n_base  = RADIX_NONE;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_rej   = 1'b0;
            n_dig   = 1'b0;
        end
    end

    // Parse state and the valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_base      <= RADIX_NONE;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_rej       <= 1'b0;
            r_dig       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_rej   <= n_rej;
                r_dig   <= n_dig;
            end
            // A token's last character loads a result; otherwise a taken result leaves.
            if (w_accept && i_in_data.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; it only loads when the register is free to take a new result.
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- sim/prefixed_integer_literal_parser_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the integer literal parser. Tokens are streamed in
// one character per transfer; a behavioral copy of the parser predicts the
// status, radix and value that each final character must produce, and every
// result transfer is compared against the oldest prediction.
module prefixed_integer_literal_parser_tb;

    import pilp_pkg::*;

    // Character codes that the parser treats specially.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_RETURN = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_G  = 8'h67;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CASE_GAP  = 8'd32;
    localparam logic [7:0] NOT_HEX   = 8'hFF;

    // The stimulus stops once the character stream reaches this length.
    localparam int STREAM_CHARS = 1540;
    // Cycles to wait after the last result; the parser registers its answer.
    localparam int TAIL_CYCLES  = 8;

    typedef enum logic [1:0] {
        SCAN_START,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_TRAIL
    } t_scan_phase;

    // One pending character; hold makes the driver wait until every
    // predicted result has been seen before it offers this character.
    typedef struct packed {
        logic     hold;
        t_in_item item;
    } t_stream_char;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    t_stream_char char_stream_q[$];
    t_out_item    expected_literal_q[$];
    logic [7:0]   token_buf[$];

    // Transfer flags captured at each rising edge and consumed by the
    // drivers at the following falling edge.
    bit in_taken;
    bit out_taken;

    int  mismatches;
    int  send_gap;
    int  recv_stall;
    bit  send_burst;
    bit  recv_burst;

    // Predicted parser state.
    t_scan_phase scan_phase;
    logic [4:0]  scan_radix;
    logic [63:0] scan_acc;
    logic        scan_ovf;
    logic        scan_bad;
    logic        scan_digit;

    prefixed_integer_literal_parser u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Behavioral parser.
    // ------------------------------------------------------------------

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_RETURN);
    endfunction

    function automatic logic [7:0] hex_value(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LOW_A && c <= CH_LOW_F) return c - CH_LOW_A + 8'd10;
        return NOT_HEX;
    endfunction

    function automatic void clear_scan();
        scan_phase = SCAN_START;
        scan_radix = RADIX_NONE;
        scan_acc   = '0;
        scan_ovf   = 1'b0;
        scan_bad   = 1'b0;
        scan_digit = 1'b0;
    endfunction

    // Multiply-and-add of one digit. Once the value no longer fits, the
    // accumulator freezes and only the overflow flag matters.
    function automatic void add_digit(logic [7:0] d);
        logic [63:0] b;
        logic [63:0] m;
        b = (scan_radix != RADIX_NONE) ? 64'(scan_radix) : 64'(RADIX_DEC);
        m = {64{1'b1}} >> (64 - VALUE_BITS);
        scan_digit = 1'b1;
        if (!scan_ovf) begin
            if (scan_acc > (m - 64'(d)) / b) begin
                scan_ovf = 1'b1;
            end else begin
                scan_acc = (scan_acc * b + 64'(d)) & m;
            end
        end
    endfunction

    // Advances the predicted state by one accepted character and, on the
    // final character of a token, queues the result the parser must give.
    function automatic void scan_literal_char(logic [7:0] raw, logic last);
        logic [7:0] c;
        logic [7:0] d;
        logic       ok;
        t_out_item  res;
        c = (raw >= CH_UP_A && raw <= CH_UP_Z) ? raw + CASE_GAP : raw;
        d = hex_value(c);
        // After a rejection every further character is ignored until the end.
        if (!scan_bad) begin
            if (c == CH_DASH) begin
                scan_bad = 1'b1;
            end else begin
                case (scan_phase)
                    SCAN_START: begin
                        if (c == CH_ZERO) begin
                            scan_phase = SCAN_ZERO;
                        end else if (c >= CH_ONE && c <= CH_NINE) begin
                            scan_radix = RADIX_DEC;
                            scan_phase = SCAN_DIGITS;
                            add_digit(d);
                        end else if (!is_blank(c)) begin
                            scan_bad = 1'b1;
                        end
                    end
                    SCAN_ZERO: begin
                        if (c == CH_LOW_B) begin
                            scan_radix = RADIX_BIN;
                            scan_phase = SCAN_DIGITS;
                        end else if (c == CH_LOW_X) begin
                            scan_radix = RADIX_HEX;
                            scan_phase = SCAN_DIGITS;
                        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
                            scan_radix = RADIX_OCT;
                            scan_phase = SCAN_DIGITS;
                            add_digit(d);
                        end else if (is_blank(c)) begin
                            scan_radix = RADIX_DEC;
                            scan_phase = SCAN_TRAIL;
                        end else begin
                            scan_bad = 1'b1;
                        end
                    end
                    SCAN_DIGITS: begin
                        if (d < 8'(scan_radix)) begin
                            add_digit(d);
                        end else if (is_blank(c) && scan_digit) begin
                            scan_phase = SCAN_TRAIL;
                        end else begin
                            scan_bad = 1'b1;
                        end
                    end
                    default: begin
                        if (!is_blank(c)) scan_bad = 1'b1;
                    end
                endcase
            end
        end
        if (last) begin
            case (scan_phase)
                SCAN_ZERO: begin
                    // A lone zero is decimal.
                    scan_radix = RADIX_DEC;
                    ok = 1'b1;
                end
                SCAN_DIGITS: ok = scan_digit;
                SCAN_TRAIL:  ok = 1'b1;
                default:     ok = 1'b0;
            endcase
            if (scan_bad) ok = 1'b0;
            res.value = '0;
            if (!ok) begin
                res.status = STATUS_NOT_NUM;
                res.radix  = RADIX_NONE;
            end else if (scan_ovf) begin
                // A rejection outranks overflow, so overflow is only seen here.
                res.status = STATUS_OVERFLOW;
                res.radix  = scan_radix;
            end else begin
                res.status = STATUS_VALID;
                res.radix  = scan_radix;
                res.value  = scan_acc;
            end
            expected_literal_q.push_back(res);
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Token construction.
    // ------------------------------------------------------------------

    function automatic bit coin();
        return $urandom_range(0, 1) == 1;
    endfunction

    function automatic int draw_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(8, 13);
        return (k == 8) ? CH_SPACE : 8'(k);
    endfunction

    // Digit character for a value, with letters in either case.
    function automatic logic [7:0] digit_char(int v);
        logic [7:0] c;
        if (v < 10) return CH_ZERO + 8'(v);
        c = CH_LOW_A + 8'(v - 10);
        return coin() ? c - CASE_GAP : c;
    endfunction

    function automatic void add_run(int radix, int n);
        for (int i = 0; i < n; i++) token_buf.push_back(digit_char($urandom_range(0, radix - 1)));
    endfunction

    function automatic void maybe_blank();
        if ($urandom_range(0, 3) == 0) token_buf.push_back(blank_char());
    endfunction

    function automatic void append_text(string s);
        for (int i = 0; i < s.len(); i++) token_buf.push_back(8'(s[i]));
    endfunction

    // Prefix letter in either case.
    function automatic void add_prefix(logic [7:0] letter);
        token_buf.push_back(CH_ZERO);
        token_buf.push_back(coin() ? letter - CASE_GAP : letter);
    endfunction

    // Moves the token under construction into the character stream, with
    // the last flag on its final character.
    function automatic void emit_token(bit hold);
        t_stream_char e;
        for (int i = 0; i < token_buf.size(); i++) begin
            e.hold      = hold && (i == 0);
            e.item.ch   = token_buf[i];
            e.item.last = (i == token_buf.size() - 1);
            char_stream_q.push_back(e);
        end
        token_buf.delete();
    endfunction

    function automatic void push_text(string s);
        append_text(s);
        emit_token(1'b0);
    endfunction

    // A well-formed literal of random base and length. Most runs are short;
    // about one in ten is long enough to sit near or beyond the 64-bit limit.
    function automatic void build_literal();
        int n;
        bit long_run;
        long_run = ($urandom_range(0, 9) == 0);
        maybe_blank();
        case ($urandom_range(0, 5))
            0: begin
                n = long_run ? $urandom_range(18, 21) : $urandom_range(1, 6);
                token_buf.push_back(digit_char($urandom_range(1, 9)));
                add_run(10, n - 1);
            end
            1: begin
                add_prefix(CH_LOW_X);
                if (long_run && coin()) begin
                    // All ones: the largest value that fits.
                    for (int i = 0; i < 16; i++) token_buf.push_back(digit_char(15));
                end else begin
                    add_run(16, long_run ? $urandom_range(15, 17) : $urandom_range(1, 8));
                end
            end
            2: begin
                add_prefix(CH_LOW_B);
                add_run(2, long_run ? $urandom_range(63, 65) : $urandom_range(1, 12));
            end
            3: begin
                token_buf.push_back(CH_ZERO);
                add_run(8, long_run ? $urandom_range(21, 23) : $urandom_range(1, 6));
            end
            4: begin
                token_buf.push_back(CH_ZERO);
            end
            default: begin
                append_text(coin() ? "18446744073709551615" : "18446744073709551616");
            end
        endcase
        maybe_blank();
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers the queued characters at the falling edge,
    // with a random gap before each one and occasional gap-free bursts.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic         nxt_valid;
        t_in_item     nxt_data;
        t_stream_char head;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && in_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (char_stream_q.size() > 0 &&
                             !(char_stream_q[0].hold && expected_literal_q.size() > 0)) begin
                    head      = char_stream_q.pop_front();
                    nxt_data  = head.item;
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
                    send_gap = draw_gap(send_burst);
                end
            end
        end
        // A single assignment per step keeps valid steady between back-to-back items.
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // ------------------------------------------------------------------
    // Result receiver: stalls each result for a random number of cycles.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            recv_stall = 0;
        end else if (out_taken) begin
            if ($urandom_range(0, 29) == 0) recv_burst = ~recv_burst;
            recv_stall = draw_gap(recv_burst);
        end else if (o_out_valid && recv_stall > 0) begin
            recv_stall--;
        end
        i_out_ready <= i_rst_n && (recv_stall == 0);
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels at the rising edge. A result never
    // comes from a character accepted at the same edge, so the order of
    // the two checks below does not matter.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        in_taken  = i_rst_n && i_in_valid && o_in_ready;
        out_taken = i_rst_n && o_out_valid && i_out_ready;
        if (out_taken) begin
            if (expected_literal_q.size() == 0) begin
                report_mismatch("result with no token pending, status", 64'(o_out_data.status), 0);
            end else begin
                want = expected_literal_q.pop_front();
                if (o_out_data.status !== want.status)
                    report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                if (o_out_data.radix !== want.radix)
                    report_mismatch("radix", 64'(o_out_data.radix), 64'(want.radix));
                if (o_out_data.value !== want.value)
                    report_mismatch("value", o_out_data.value, want.value);
            end
        end
        if (in_taken) scan_literal_char(i_in_data.ch, i_in_data.last);
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        int pick;
        int spot;
        int n;
        int tokens;
        clear_scan();
        mismatches = 0;
        send_gap   = 0;
        recv_stall = 0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        tokens     = 0;

        // Directed tokens: a lone zero with and without trailing space, a
        // bare prefix, a short binary run, a dash, blanks only, a bad octal
        // start, a second prefix, NUL and the top character code, folded
        // upper case, a dash after a prefix, and a hex value one past the
        // 64-bit limit.
        push_text("0");
        push_text("0 ");
        push_text("0x");
        push_text("0b1");
        push_text("-");
        push_text(" ");
        push_text("08");
        push_text("0bx");
        token_buf.push_back(8'h00);
        emit_token(1'b0);
        token_buf.push_back(8'hFF);
        emit_token(1'b0);
        push_text("0XF");
        push_text("0x-1");
        push_text("0x10000000000000000");

        // Random tokens: mostly well-formed literals, the rest corrupted
        // literals, overflow followed by a bad character, bare prefixes,
        // blank-only tokens and raw byte noise.
        while (char_stream_q.size() < STREAM_CHARS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                build_literal();
            end else if (pick < 80) begin
                build_literal();
                spot = $urandom_range(0, token_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0:       token_buf[spot] = CH_DASH;
                    1:       token_buf[spot] = CH_LOW_X;
                    2:       token_buf[spot] = CH_LOW_B;
                    default: token_buf[spot] = 8'($urandom_range(0, 255));
                endcase
            end else if (pick < 85) begin
                add_prefix(CH_LOW_X);
                add_run(16, 17);
                token_buf.push_back(coin() ? CH_LOW_G : 8'($urandom_range(0, 255)));
            end else if (pick < 90) begin
                add_prefix(coin() ? CH_LOW_X : CH_LOW_B);
                maybe_blank();
            end else if (pick < 94) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) token_buf.push_back(blank_char());
            end else begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) token_buf.push_back(8'($urandom_range(0, 255)));
            end
            // The first random token, and about one in a hundred after it,
            // waits for the result stream to drain completely.
            emit_token(tokens == 0 || $urandom_range(0, 99) == 0);
            tokens++;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_stream_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_literal_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && expected_literal_q.size() == 0) begin
            $display("prefixed_integer_literal_parser_tb: PASS");
        end else begin
            $display("prefixed_integer_literal_parser_tb: FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("prefixed_integer_literal_parser_tb: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pilp_pkg.sv
rtl/prefixed_integer_literal_parser.sv
sim/prefixed_integer_literal_parser_tb.sv
